>>> src/fctp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour-code text parser package
// Shared types, codes and character constants for the parser blocks.
// ----------------------------------------------------------------------------
package fctp_pkg;

    // Input item kinds.
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Result kinds.
    localparam logic [1:0] RES_TEXT    = 2'd0;
    localparam logic [1:0] RES_SEGMENT = 2'd1;
    localparam logic [1:0] RES_LINE    = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_RESET_ON_COLOR = 1'b0;
    localparam logic CFG_RESET_ON_LINE  = 1'b1;

    // Characters with a meaning to the parser.
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_BOLD    = 8'h6c;
    localparam logic [7:0] CH_ITALIC  = 8'h6f;
    localparam logic [7:0] CH_UNDER   = 8'h6e;
    localparam logic [7:0] CH_STRIKE  = 8'h6d;
    localparam logic [7:0] CH_OBFUSC  = 8'h6b;
    localparam logic [7:0] CH_RESET   = 8'h72;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    // Style flag bit positions.
    localparam int FLAG_BOLD   = 0;
    localparam int FLAG_ITALIC = 1;
    localparam int FLAG_UNDER  = 2;
    localparam int FLAG_STRIKE = 3;
    localparam int FLAG_OBFUSC = 4;

    localparam logic [2:0] HEX_MAX   = 3'd6;
    localparam int         MAX_RES   = 3;
    localparam logic [3:0] DEFAULT_INDEX = 4'd5;   // default palette colour

    typedef struct packed {
        logic        kind;
        logic [7:0]  text_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind_res;
        logic [7:0]  out_byte;
        logic        color_is_hex;
        logic [3:0]  color_index;
        logic [47:0] color_chars;
        logic [2:0]  color_chars_len;
        logic        bold;
        logic        italic;
        logic        underlined;
        logic        strikethrough;
        logic        obfuscated;
        logic        last_of_item;
    } t_res;

    typedef t_res [MAX_RES-1:0] t_res_vec;
    typedef logic [1:0]          t_res_cnt;

    typedef struct packed {
        logic        is_hex;
        logic [3:0]  index;
        logic [47:0] chars;
        logic [2:0]  chars_len;
        logic [4:0]  flags;
    } t_style;

    typedef struct packed {
        t_style      style;
        logic        esc;
        logic [2:0]  cap_left;
        logic        text_open;
        logic        line_open;
    } t_pstate;

    typedef struct packed {
        logic        reset_on_color;
        logic        reset_on_line;
    } t_cfg;

    localparam t_style STYLE_DEFAULT = '{1'b0, DEFAULT_INDEX, 48'd0, 3'd0, 5'd0};
    localparam t_pstate PSTATE_RESET = '{STYLE_DEFAULT, 1'b0, 3'd0, 1'b0, 1'b0};

endpackage

>>> src/fctp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text input channel
// Valid/ready channel carrying one text byte or an end-of-text marker.
// ----------------------------------------------------------------------------
interface fctp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] text_byte;

    modport source (output valid, output kind, output text_byte, input ready);
    modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

>>> src/fctp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser result channel
// Valid/ready channel carrying one text byte, segment end or line end.
// ----------------------------------------------------------------------------
interface fctp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind_res;
    logic [7:0]  out_byte;
    logic        color_is_hex;
    logic [3:0]  color_index;
    logic [47:0] color_chars;
    logic [2:0]  color_chars_len;
    logic        bold;
    logic        italic;
    logic        underlined;
    logic        strikethrough;
    logic        obfuscated;
    logic        last_of_item;

    modport source (
        output valid, output kind_res, output out_byte, output color_is_hex,
        output color_index, output color_chars, output color_chars_len,
        output bold, output italic, output underlined, output strikethrough,
        output obfuscated, output last_of_item, input ready
    );
    modport sink (
        input valid, input kind_res, input out_byte, input color_is_hex,
        input color_index, input color_chars, input color_chars_len,
        input bold, input italic, input underlined, input strikethrough,
        input obfuscated, input last_of_item, output ready
    );
endinterface

>>> src/format_code_text_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour-code text parser
// Parses '&' style codes in a byte stream into text, segment and line results.
// ----------------------------------------------------------------------------
// Bytes arrive as requests on i_text and pass through an item register, a
// single step of parse logic and a three-entry result buffer that drives
// o_res. An item that yields at most one result flows at one request per
// clock while o_res is ready; an item that yields several results holds the
// buffer while it hands them out at one result per clock as o_res allows, and
// the item register takes the following request meanwhile. The user must write
// the configuration registers through i_cfg_* only while the block is idle;
// the block itself does not enforce this. Index 0 is reset_on_color and index
// 1 is reset_on_line.
module format_code_text_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fctp_in_if.sink          i_text,
    fctp_out_if.source       o_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic             i_cfg_data
);
    import fctp_pkg::*;

    // Item register: holds one request until the result buffer has room.
    t_item    r_item;
    logic     r_item_v;
    t_pstate  r_state;
    t_pstate  n_state;
    t_cfg     r_cfg;
    t_res_vec step_res;
    t_res_cnt step_cnt;
    t_res     head;
    logic     can_load;
    logic     proc;
    logic     accept;

    assign proc         = r_item_v && can_load;
    assign i_text.ready = !r_item_v || proc;
    assign accept       = i_text.valid && i_text.ready;

    fctp_core u_core (
        .i_item  (r_item),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_res   (step_res),
        .o_cnt   (step_cnt)
    );

    fctp_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (proc),
        .i_res      (step_res),
        .i_cnt      (step_cnt),
        .o_can_load (can_load),
        .o_valid    (o_res.valid),
        .i_ready    (o_res.ready),
        .o_head     (head)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.kind      <= i_text.kind;
            r_item.text_byte <= i_text.text_byte;
        end
        if (!i_rst_n) begin
            r_item_v <= 1'b0;
            r_state  <= PSTATE_RESET;
            r_cfg    <= '0;
        end else begin
            if (accept) begin
                r_item_v <= 1'b1;
            end else if (proc) begin
                r_item_v <= 1'b0;
            end
            // The parse state advances as each item's results are stored.
            if (proc) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RESET_ON_COLOR: r_cfg.reset_on_color <= i_cfg_data;
                    CFG_RESET_ON_LINE:  r_cfg.reset_on_line  <= i_cfg_data;
                    default:            r_cfg                <= r_cfg;
                endcase
            end
        end
    end

    assign o_res.kind_res        = head.kind_res;
    assign o_res.out_byte        = head.out_byte;
    assign o_res.color_is_hex    = head.color_is_hex;
    assign o_res.color_index     = head.color_index;
    assign o_res.color_chars     = head.color_chars;
    assign o_res.color_chars_len = head.color_chars_len;
    assign o_res.bold            = head.bold;
    assign o_res.italic          = head.italic;
    assign o_res.underlined      = head.underlined;
    assign o_res.strikethrough   = head.strikethrough;
    assign o_res.obfuscated      = head.obfuscated;
    assign o_res.last_of_item    = head.last_of_item;

endmodule

>>> src/fctp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser step logic
// Works out the results of one item and the parse state it leaves behind.
// ----------------------------------------------------------------------------
module fctp_core (
    input  fctp_pkg::t_item    i_item,
    input  fctp_pkg::t_pstate  i_state,
    input  fctp_pkg::t_cfg     i_cfg,
    output fctp_pkg::t_pstate  o_state,
    output fctp_pkg::t_res_vec o_res,
    output fctp_pkg::t_res_cnt o_cnt
);
    import fctp_pkg::*;

    function automatic t_res mk_text(input logic [7:0] b);
        t_res r;
        r          = '0;
        r.kind_res = RES_TEXT;
        r.out_byte = b;
        return r;
    endfunction

    function automatic t_res mk_seg(input t_style s);
        t_res r;
        r              = '0;
        r.kind_res     = RES_SEGMENT;
        r.color_is_hex = s.is_hex;
        if (s.is_hex) begin
            r.color_chars     = s.chars;
            r.color_chars_len = s.chars_len;
        end else begin
            r.color_index = s.index;
        end
        r.bold          = s.flags[FLAG_BOLD];
        r.italic        = s.flags[FLAG_ITALIC];
        r.underlined    = s.flags[FLAG_UNDER];
        r.strikethrough = s.flags[FLAG_STRIKE];
        r.obfuscated    = s.flags[FLAG_OBFUSC];
        return r;
    endfunction

    function automatic t_res mk_line();
        t_res r;
        r          = '0;
        r.kind_res = RES_LINE;
        return r;
    endfunction

    t_pstate    s;
    t_res_vec   res;
    t_res_cnt   cnt;
    logic [7:0] b;
    logic       pal_ok;
    logic [3:0] pal_code;

    always_comb begin
        b = i_item.text_byte;
        pal_ok   = 1'b0;
        pal_code = 4'd0;
        if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) begin
            pal_ok   = 1'b1;
            pal_code = 4'(b - CH_DIGIT_0);
        end else if (b >= CH_LOWER_A && b <= CH_LOWER_F) begin
            pal_ok   = 1'b1;
            pal_code = 4'(b - CH_LOWER_A + 8'd10);
        end
    end

    always_comb begin
        s   = i_state;
        res = '0;
        cnt = 2'd0;

        if (i_item.kind == KIND_END || b == CH_LF) begin
            // Close the line: a dangling ampersand is plain text.
            if (i_item.kind == KIND_TEXT || s.line_open) begin
                if (s.esc) begin
                    res[cnt] = mk_text(CH_AMP);
                    cnt      = cnt + 2'd1;
                end
                res[cnt] = mk_seg(s.style);
                cnt      = cnt + 2'd1;
                res[cnt] = mk_line();
                cnt      = cnt + 2'd1;
                s.esc       = 1'b0;
                s.cap_left  = 3'd0;
                s.text_open = 1'b0;
                s.line_open = 1'b0;
            end
            if (i_item.kind == KIND_END) begin
                s = PSTATE_RESET;
            end else if (i_cfg.reset_on_line) begin
                s.style = STYLE_DEFAULT;
            end
        end else begin
            s.line_open = 1'b1;
            if (s.cap_left != 3'd0) begin
                s.style.chars = {s.style.chars[39:0], b};
                if (s.style.chars_len < HEX_MAX) begin
                    s.style.chars_len = s.style.chars_len + 3'd1;
                end
                s.cap_left = s.cap_left - 3'd1;
            end else if (s.esc) begin
                s.esc = 1'b0;
                // A code closes any open text with the style it had.
                if (s.text_open) begin
                    res[cnt]    = mk_seg(s.style);
                    cnt         = cnt + 2'd1;
                    s.text_open = 1'b0;
                end
                if (b == CH_HASH) begin
                    if (i_cfg.reset_on_color) begin
                        s.style = STYLE_DEFAULT;
                    end
                    s.style.is_hex    = 1'b1;
                    s.style.chars     = '0;
                    s.style.chars_len = 3'd0;
                    s.cap_left        = HEX_MAX;
                end else if (b == CH_BOLD) begin
                    s.style.flags[FLAG_BOLD] = 1'b1;
                end else if (b == CH_ITALIC) begin
                    s.style.flags[FLAG_ITALIC] = 1'b1;
                end else if (b == CH_UNDER) begin
                    s.style.flags[FLAG_UNDER] = 1'b1;
                end else if (b == CH_STRIKE) begin
                    s.style.flags[FLAG_STRIKE] = 1'b1;
                end else if (b == CH_OBFUSC) begin
                    s.style.flags[FLAG_OBFUSC] = 1'b1;
                end else if (b == CH_RESET) begin
                    s.style = STYLE_DEFAULT;
                end else if (pal_ok) begin
                    if (i_cfg.reset_on_color) begin
                        s.style = STYLE_DEFAULT;
                    end
                    s.style.is_hex    = 1'b0;
                    s.style.chars     = '0;
                    s.style.chars_len = 3'd0;
                    s.style.index     = pal_code;
                end else if (b == CH_AMP) begin
                    // Unknown code that opens a new escape.
                    s.esc = 1'b1;
                end else begin
                    res[cnt]    = mk_text(b);
                    cnt         = cnt + 2'd1;
                    s.text_open = 1'b1;
                end
            end else if (b == CH_AMP) begin
                s.esc = 1'b1;
            end else begin
                res[cnt]    = mk_text(b);
                cnt         = cnt + 2'd1;
                s.text_open = 1'b1;
            end
        end

        if (cnt != 2'd0) begin
            res[cnt - 2'd1].last_of_item = 1'b1;
        end
    end

    assign o_state = s;
    assign o_res   = res;
    assign o_cnt   = cnt;

endmodule

>>> src/fctp_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result buffer
// Holds the up to three results of one item and hands them out in order.
// ----------------------------------------------------------------------------
module fctp_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  fctp_pkg::t_res_vec i_res,
    input  fctp_pkg::t_res_cnt i_cnt,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output fctp_pkg::t_res     o_head
);
    import fctp_pkg::*;

    t_res_vec r_slot;
    t_res_vec n_slot;
    t_res_cnt r_cnt;
    t_res_cnt n_cnt;
    logic     pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign pop        = o_valid && i_ready;
    // New results may land when the buffer is empty or its last one leaves this cycle.
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);
    assign o_head     = r_slot[0];

    always_comb begin
        n_slot = r_slot;
        n_cnt  = r_cnt;
        if (i_load) begin
            n_slot = i_res;
            n_cnt  = i_cnt;
        end else if (pop) begin
            n_slot[0] = r_slot[1];
            n_slot[1] = r_slot[2];
            n_cnt     = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> tb/fctp_parse_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour-code parser result checker
// Watches the request and result channels and the register write port, keeps
// its own copy of the parse state and compares every result as it leaves.
// ----------------------------------------------------------------------------
module fctp_parse_check
    import fctp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    fctp_in_if   i_text,
    fctp_out_if  i_res,
    input  logic i_cfg_we,
    input  logic i_cfg_index,
    input  logic i_cfg_data,
    output int   o_fail_count,
    output int   o_results_owed
);

    localparam int REPORT_MAX = 10;

    t_style     cur_style;
    logic       esc_pending;
    logic [2:0] hex_left;
    logic       seg_open;
    logic       line_open;
    t_cfg       cfg;
    t_res       owed_q[$];
    t_res       batch[$];
    int         reported;

    function automatic t_res text_result(input logic [7:0] b);
        t_res r;
        r = '0;
        r.kind_res = RES_TEXT;
        r.out_byte = b;
        return r;
    endfunction

    function automatic t_res segment_result(input t_style s);
        t_res r;
        r = '0;
        r.kind_res     = RES_SEGMENT;
        r.color_is_hex = s.is_hex;
        if (s.is_hex) begin
            r.color_chars     = s.chars;
            r.color_chars_len = s.chars_len;
        end else begin
            r.color_index = s.index;
        end
        r.bold          = s.flags[FLAG_BOLD];
        r.italic        = s.flags[FLAG_ITALIC];
        r.underlined    = s.flags[FLAG_UNDER];
        r.strikethrough = s.flags[FLAG_STRIKE];
        r.obfuscated    = s.flags[FLAG_OBFUSC];
        return r;
    endfunction

    function automatic string show(input t_res r);
        return $sformatf(
            "kind %0d byte %02h hex %0b idx %0d chars %012h len %0d flags %05b last %0b",
            r.kind_res, r.out_byte, r.color_is_hex, r.color_index, r.color_chars,
            r.color_chars_len,
            {r.obfuscated, r.strikethrough, r.underlined, r.italic, r.bold},
            r.last_of_item);
    endfunction

    // A pending '&' at the end of a line is plain text.
    task automatic close_line();
        t_res r;
        if (esc_pending)
            batch = {batch, text_result(CH_AMP)};
        batch = {batch, segment_result(cur_style)};
        r = '0;
        r.kind_res = RES_LINE;
        batch = {batch, r};
        esc_pending = 1'b0;
        hex_left    = 3'd0;
        seg_open    = 1'b0;
        line_open   = 1'b0;
    endtask

    task automatic ordinary_byte(input logic [7:0] b);
        if (b == CH_AMP) begin
            esc_pending = 1'b1;
        end else begin
            batch = {batch, text_result(b)};
            seg_open = 1'b1;
        end
    endtask

    task automatic parse_request(input logic kind, input logic [7:0] b);
        logic       pal_hit;
        logic [7:0] offs;
        batch.delete();
        if (kind == KIND_END) begin
            if (line_open)
                close_line();
            cur_style   = STYLE_DEFAULT;
            esc_pending = 1'b0;
            hex_left    = 3'd0;
            seg_open    = 1'b0;
            line_open   = 1'b0;
        end else if (b == CH_LF) begin
            close_line();
            if (cfg.reset_on_line)
                cur_style = STYLE_DEFAULT;
        end else begin
            line_open = 1'b1;
            if (hex_left != 3'd0) begin
                cur_style.chars = {cur_style.chars[39:0], b};
                if (cur_style.chars_len < HEX_MAX)
                    cur_style.chars_len = cur_style.chars_len + 3'd1;
                hex_left = hex_left - 3'd1;
            end else if (esc_pending) begin
                esc_pending = 1'b0;
                if (seg_open) begin
                    batch = {batch, segment_result(cur_style)};
                    seg_open = 1'b0;
                end
                case (b)
                    CH_HASH: begin
                        if (cfg.reset_on_color)
                            cur_style = STYLE_DEFAULT;
                        cur_style.is_hex    = 1'b1;
                        cur_style.chars     = '0;
                        cur_style.chars_len = 3'd0;
                        hex_left            = HEX_MAX;
                    end
                    CH_BOLD:   cur_style.flags[FLAG_BOLD]   = 1'b1;
                    CH_ITALIC: cur_style.flags[FLAG_ITALIC] = 1'b1;
                    CH_UNDER:  cur_style.flags[FLAG_UNDER]  = 1'b1;
                    CH_STRIKE: cur_style.flags[FLAG_STRIKE] = 1'b1;
                    CH_OBFUSC: cur_style.flags[FLAG_OBFUSC] = 1'b1;
                    CH_RESET:  cur_style = STYLE_DEFAULT;
                    default: begin
                        pal_hit = 1'b1;
                        offs    = 8'd0;
                        if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9)
                            offs = b - CH_DIGIT_0;
                        else if (b >= CH_LOWER_A && b <= CH_LOWER_F)
                            offs = b - CH_LOWER_A + 8'd10;
                        else
                            pal_hit = 1'b0;
                        if (pal_hit) begin
                            if (cfg.reset_on_color)
                                cur_style = STYLE_DEFAULT;
                            cur_style.is_hex    = 1'b0;
                            cur_style.chars     = '0;
                            cur_style.chars_len = 3'd0;
                            cur_style.index     = offs[3:0];
                        end else begin
                            // Unknown code: the '&' goes, the byte stays.
                            ordinary_byte(b);
                        end
                    end
                endcase
            end else begin
                ordinary_byte(b);
            end
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last_of_item = 1'b1;
        foreach (batch[k])
            owed_q = {owed_q, batch[k]};
    endtask

    always @(posedge i_clk) begin : watch
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            cur_style   = STYLE_DEFAULT;
            esc_pending = 1'b0;
            hex_left    = 3'd0;
            seg_open    = 1'b0;
            line_open   = 1'b0;
            cfg         = '0;
            owed_q.delete();
            reported       = 0;
            o_fail_count   = 0;
            o_results_owed = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_RESET_ON_COLOR)
                    cfg.reset_on_color = i_cfg_data;
                else
                    cfg.reset_on_line = i_cfg_data;
            end
            if (i_text.valid && i_text.ready)
                parse_request(i_text.kind, i_text.text_byte);
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.kind_res, i_res.out_byte, i_res.color_is_hex, i_res.color_index,
                        i_res.color_chars, i_res.color_chars_len, i_res.bold, i_res.italic,
                        i_res.underlined, i_res.strikethrough, i_res.obfuscated,
                        i_res.last_of_item};
                if (owed_q.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (reported < REPORT_MAX) begin
                        reported = reported + 1;
                        $display("%0t: result with none expected: %s", $realtime, show(got));
                    end
                end else begin
                    want = owed_q.pop_front();
                    if (got !== want) begin
                        o_fail_count = o_fail_count + 1;
                        if (reported < REPORT_MAX) begin
                            reported = reported + 1;
                            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                                     $realtime, show(want), show(got));
                        end
                    end
                end
            end
            o_results_owed = owed_q.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour-code text parser testbench
// Drives directed and random byte streams through the parser under changing
// register settings and flow-control patterns; the checker beside the block
// predicts every result and counts any difference.
// ----------------------------------------------------------------------------
module testbench;
    import fctp_pkg::*;

    // A watchdog ends the run if nothing moves on either channel for this long.
    // The longest legal quiet stretch is the deliberate receiver hold-off.
    localparam int IDLE_LIMIT      = 3000;
    // Cycles allowed after the last result for a request that yields nothing.
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 112;
    localparam int HOLD_AT         = 200;
    localparam int HOLD_CYCLES     = 300;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic cfg_data;
    int   send_idle;
    int   recv_idle;
    int   sent_count;
    int   fail_count;
    int   results_owed;

    fctp_in_if  text_if ();
    fctp_out_if res_if ();

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    format_code_text_parser u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_text      (text_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fctp_parse_check u_parse_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_text         (text_if),
        .i_res          (res_if),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_results_owed (results_owed)
    );

    // Offers one request from the falling edge, idling first at the current
    // rate, and returns at the rising edge where it is taken.
    task automatic send_item(input logic kind, input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle) begin
            text_if.valid <= 1'b0;
            @(negedge clk);
        end
        text_if.valid     <= 1'b1;
        text_if.kind      <= kind;
        text_if.text_byte <= b;
        do
            @(posedge clk);
        while (!(text_if.valid && text_if.ready));
        sent_count = sent_count + 1;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_item(KIND_TEXT, s[k]);
    endtask

    // Register writes happen only with the parser idle.
    task automatic write_cfg(input logic idx, input logic val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stops offering, waits for every predicted result and then lets the
    // pipeline empty out, since some requests leave no result behind them.
    task automatic drain();
        @(negedge clk);
        text_if.valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One piece of a well-formed stream, now and then a piece of noise.
    // Mostly plain text and valid codes so that styles build up over a line.
    task automatic send_token();
        int         pick;
        int         n;
        logic [7:0] b;
        string      palette;
        string      flag_codes;
        palette    = "0123456789abcdef";
        flag_codes = "lonmk";
        pick = $urandom_range(99);
        if (pick < 35) begin
            do
                b = 8'($urandom_range(255));
            while (b == CH_AMP || b == CH_LF);
            send_item(KIND_TEXT, b);
        end else if (pick < 50) begin
            send_item(KIND_TEXT, CH_AMP);
            send_item(KIND_TEXT, palette[$urandom_range(15)]);
        end else if (pick < 62) begin
            send_item(KIND_TEXT, CH_AMP);
            send_item(KIND_TEXT, flag_codes[$urandom_range(4)]);
        end else if (pick < 67) begin
            send_item(KIND_TEXT, CH_AMP);
            send_item(KIND_TEXT, CH_RESET);
        end else if (pick < 77) begin
            // Raw colour; fewer than six bytes lets a newline cut it short
            // or lets ordinary text finish the capture.
            send_item(KIND_TEXT, CH_AMP);
            send_item(KIND_TEXT, CH_HASH);
            n = $urandom_range(6);
            repeat (n) begin
                do
                    b = 8'($urandom_range(255));
                while (b == CH_LF);
                send_item(KIND_TEXT, b);
            end
        end else if (pick < 82) begin
            // Unknown code, which may itself be another '&'.
            do
                b = 8'($urandom_range(255));
            while (b == CH_LF || b == CH_HASH || b == CH_BOLD || b == CH_ITALIC ||
                   b == CH_UNDER || b == CH_STRIKE || b == CH_OBFUSC || b == CH_RESET ||
                   (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) ||
                   (b >= CH_LOWER_A && b <= CH_LOWER_F));
            send_item(KIND_TEXT, CH_AMP);
            send_item(KIND_TEXT, b);
        end else if (pick < 87) begin
            send_item(KIND_TEXT, CH_LF);
        end else if (pick < 89) begin
            send_item(KIND_TEXT, CH_AMP);
            send_item(KIND_TEXT, CH_LF);
        end else if (pick < 91) begin
            if ($urandom_range(1) == 0)
                send_item(KIND_TEXT, CH_AMP);
            send_item(KIND_END, 8'($urandom_range(255)));
        end else if (pick < 95) begin
            send_item(($urandom_range(7) == 0) ? KIND_END : KIND_TEXT,
                      8'($urandom_range(255)));
        end else begin
            // A run of empty lines.
            send_item(KIND_TEXT, CH_LF);
            send_item(KIND_TEXT, CH_LF);
        end
    endtask

    // The receiver takes results at the current idle rate, apart from one long
    // hold-off part-way through, during which the sender keeps offering so
    // that the result buffer fills and the input side backs up.
    initial begin : result_sink
        int  stall_left;
        bit  hold_done;
        stall_left   = 0;
        hold_done    = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left   = stall_left - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((text_if.valid && text_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin : stimulus
        int   phase;
        int   target;
        logic color_reset;
        logic line_reset;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_RESET_ON_COLOR;
        cfg_data          = 1'b0;
        text_if.valid     = 1'b0;
        text_if.kind      = KIND_TEXT;
        text_if.text_byte = 8'd0;
        sent_count        = 0;
        send_idle         = 18;
        recv_idle         = 57;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        write_cfg(CFG_RESET_ON_COLOR, 1'b0);
        write_cfg(CFG_RESET_ON_LINE, 1'b0);

        // Directed: byte extremes, a palette code closing open text, all five
        // flags, a raw colour cut short by a newline, an empty line, an
        // unknown code, palette zero, a style reset, an '&' before a newline
        // and an '&' before the end of text.
        send_item(KIND_TEXT, 8'hFF);
        send_text("&f");
        send_item(KIND_TEXT, 8'h00);
        send_text("&l&o&n&m&k&#12\n\n&z&0&r&\n&");
        send_item(KIND_END, 8'hFF);
        drain();

        // Random phases under every register setting; the idle pattern moves
        // from a slow receiver to a slow sender and then to full rate.
        for (phase = 0; phase < 4; phase++) begin
            color_reset = (phase % 2 == 0);
            line_reset  = (phase == 1 || phase == 2);
            if (phase < 2) begin
                send_idle = 18;
                recv_idle = 57;
            end else if (phase == 2) begin
                send_idle = 57;
                recv_idle = 18;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_cfg(CFG_RESET_ON_COLOR, color_reset);
            write_cfg(CFG_RESET_ON_LINE, line_reset);
            target = sent_count + ITEMS_PER_PHASE;
            while (sent_count < target)
                send_token();
            drain();
        end

        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
